// ===== rtl/core/bracket_balance_checker_assert.svh =====
// Assertion macros shared by the bracket balance checker's checker module
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket balance checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket balance checker: next-cycle implication failed");

`endif

// ===== rtl/core/bbc_pkg.sv =====
// Shared types and constants of the bracket balance checker
`default_nettype none

package bbc_pkg;

    localparam int unsigned STACK_DEPTH_DEFAULT = 256;
    localparam int unsigned DEPTH_OUT_W         = 9;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic                   balanced;
        logic                   mismatch;
        logic                   overflow;
        logic [DEPTH_OUT_W-1:0] open_depth;
    } result_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/bbc_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given payload type
`default_nettype none

interface bbc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bracket_balance_checker.sv =====
// Bracket balance checker: stack of bracket kinds held in a RAM
//
// Input channel chars carries one character a cycle with a last_char flag.
// Openers ( [ { are pushed, closers ) ] } pop a matching kind. A wrong kind
// or a closer on an empty stack latches a mismatch, after which the rest of
// the expression is ignored. An opener on a full stack latches overflow.
// On the item marked last_char one result appears on the results channel
// (balanced, mismatch, overflow, open_depth) in the cycle after acceptance,
// and the stack state returns to empty for the next expression.
// Throughput: one character per cycle while chars.ready is high. The top of
// stack sits in a register; the RAM is read every cycle at the entry below
// the next top, so a pop has its new top ready from the registered RAM read.
// The result sits in an output register: input is taken whenever that
// register is empty or being emptied in the same cycle, so a stalled
// receiver holds the block only while an unclaimed result is waiting.
// Reset (rst_n low, asynchronous) empties the stack and clears both latches
// and empties the output register; no clearing pass of the RAM is needed.
`default_nettype none

module bracket_balance_checker #(
    parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bbc_stream_if.sink        chars,
    bbc_stream_if.source      results
);
    import bbc_pkg::*;

    localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    logic [DEPTH_W-1:0] depth_reg, depth_step, depth_next;
    logic               mismatch_reg, mismatch_step, mismatch_next;
    logic               overflow_reg, overflow_step, overflow_next;
    logic [1:0]         top_reg, top_step, top_next;
    logic               out_valid_reg, out_valid_next;
    result_item_t       result_reg, result_next;

    logic        accept;
    logic        is_open;
    logic        is_close;
    logic [1:0]  kind;
    logic        wr_en;
    logic [1:0]  below_top;

    assign chars.ready = !out_valid_reg || results.ready;
    assign accept      = chars.valid && chars.ready;

    always_comb
    begin
        is_open  = 1'b0;
        is_close = 1'b0;
        kind     = KIND_ROUND;
        case (chars.data.character)
            CH_OPEN_ROUND:   begin is_open  = 1'b1; kind = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin is_open  = 1'b1; kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin is_open  = 1'b1; kind = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin is_close = 1'b1; kind = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin is_close = 1'b1; kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin is_close = 1'b1; kind = KIND_CURLY;  end
            default:         begin is_open  = 1'b0; is_close = 1'b0;    end
        endcase
    end

    // Apply one character to the stack state
    always_comb
    begin
        depth_step    = depth_reg;
        top_step      = top_reg;
        mismatch_step = mismatch_reg;
        overflow_step = overflow_reg;
        wr_en         = 1'b0;
        if (accept && !mismatch_reg)
        begin
            if (is_open)
            begin
                if (depth_reg == DEPTH_FULL)
                begin
                    overflow_step = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    depth_step = depth_reg + DEPTH_W'(1);
                    top_step   = kind;
                end
            end
            else if (is_close)
            begin
                if (depth_reg == '0 || top_reg != kind)
                begin
                    mismatch_step = 1'b1;
                end
                else
                begin
                    depth_step = depth_reg - DEPTH_W'(1);
                    top_step   = below_top;
                end
            end
        end
    end

    // Return to empty after the last character of an expression
    always_comb
    begin
        depth_next    = depth_step;
        top_next      = top_step;
        mismatch_next = mismatch_step;
        overflow_next = overflow_step;
        if (accept && chars.data.last_char)
        begin
            depth_next    = '0;
            mismatch_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (accept && chars.data.last_char)
        begin
            out_valid_next        = 1'b1;
            result_next.balanced  = !mismatch_step && !overflow_step && depth_step == '0;
            result_next.mismatch  = mismatch_step;
            result_next.overflow  = overflow_step;
            result_next.open_depth = DEPTH_OUT_W'(depth_step);
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            mismatch_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            mismatch_reg  <= mismatch_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        result_reg <= result_next;
    end

    // Push writes the old depth slot; read the slot below the next top
    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (depth_reg[ADDR_W-1:0]),
        .wr_data (kind),
        .rd_addr (ADDR_W'(depth_next - DEPTH_W'(2))),
        .rd_data (below_top)
    );

    assign results.valid = out_valid_reg;
    assign results.data  = result_reg;
endmodule

`default_nettype wire

// ===== rtl/core/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module bbc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

`default_nettype wire

// ===== rtl/core/bbc_checker.sv =====
// Port-level assertions for the bracket balance checker, with its bind
`default_nettype none
`include "bracket_balance_checker_assert.svh"

module bbc_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  in_last,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire bbc_pkg::result_item_t out_data
);
    import bbc_pkg::*;

    // A waiting result stays valid until taken
    `BBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // A fresh result only follows an accepted last character
    `BBC_ASSERT_IMPLY(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_last))
    // Input is never blocked while the output register is empty
    `BBC_ASSERT_IMPLY(a_in_free, clk, rst_n, !out_valid, in_ready)
    // Balanced excludes every failure indication
    `BBC_ASSERT_IMPLY(a_bal_clean, clk, rst_n, out_valid && out_data.balanced, !out_data.mismatch && !out_data.overflow && out_data.open_depth == '0)
endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .in_last   (chars.data.last_char),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

`default_nettype wire

// ===== bench/bbc_tb_pkg.sv =====
// Bracket kinds, character codes and the result scoreboard for the bracket checker bench
package bbc_tb_pkg;

    import bbc_pkg::*;

    localparam int unsigned BRACKET_DEPTH = STACK_DEPTH_DEFAULT;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [7:0] CH_OPEN_ROUND   = "(";
    localparam logic [7:0] CH_OPEN_SQUARE  = "[";
    localparam logic [7:0] CH_OPEN_CURLY   = "{";
    localparam logic [7:0] CH_CLOSE_ROUND  = ")";
    localparam logic [7:0] CH_CLOSE_SQUARE = "]";
    localparam logic [7:0] CH_CLOSE_CURLY  = "}";

    typedef enum logic [1:0] {
        KIND_ROUND,
        KIND_SQUARE,
        KIND_CURLY,
        KIND_NONE
    } bracket_kind_e;

    function automatic bracket_kind_e opener_kind_of(logic [7:0] c);
        case (c)
            CH_OPEN_ROUND:  return KIND_ROUND;
            CH_OPEN_SQUARE: return KIND_SQUARE;
            CH_OPEN_CURLY:  return KIND_CURLY;
            default:        return KIND_NONE;
        endcase
    endfunction

    function automatic bracket_kind_e closer_kind_of(logic [7:0] c);
        case (c)
            CH_CLOSE_ROUND:  return KIND_ROUND;
            CH_CLOSE_SQUARE: return KIND_SQUARE;
            CH_CLOSE_CURLY:  return KIND_CURLY;
            default:         return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] opener_char(bracket_kind_e k);
        case (k)
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ROUND;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(bracket_kind_e k);
        case (k)
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ROUND;
        endcase
    endfunction

    class bracket_scoreboard;

        bracket_kind_e open_stack [BRACKET_DEPTH];
        int unsigned   open_count;
        bit            wrong_closer_seen;
        bit            stack_overflowed;
        result_item_t  expected_q [$];
        int unsigned   results_seen;
        int unsigned   fail_count;

        function new();
            clear_expression();
            results_seen = 0;
            fail_count   = 0;
        endfunction

        function void clear_expression();
            open_count        = 0;
            wrong_closer_seen = 1'b0;
            stack_overflowed  = 1'b0;
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the stack by one accepted character; queue a verdict on the last one
        function void note_char(char_item_t item);
            bracket_kind_e k;
            result_item_t  verdict;
            if (!wrong_closer_seen) begin
                k = opener_kind_of(item.character);
                if (k != KIND_NONE) begin
                    if (open_count >= BRACKET_DEPTH)
                        stack_overflowed = 1'b1;
                    else
                    begin
                        open_stack[open_count] = k;
                        open_count++;
                    end
                end
                else
                begin
                    k = closer_kind_of(item.character);
                    if (k != KIND_NONE) begin
                        if (open_count == 0 || open_stack[open_count - 1] != k)
                            wrong_closer_seen = 1'b1;
                        else
                            open_count--;
                    end
                end
            end
            if (item.last_char) begin
                verdict.balanced   = !wrong_closer_seen && !stack_overflowed && open_count == 0;
                verdict.mismatch   = wrong_closer_seen;
                verdict.overflow   = stack_overflowed;
                verdict.open_depth = open_count[DEPTH_OUT_W-1:0];
                expected_q.push_back(verdict);
                clear_expression();
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                flag($sformatf("result %0d arrived with none outstanding: bal=%0b mis=%0b ovf=%0b depth=%0d",
                               results_seen, got.balanced, got.mismatch, got.overflow,
                               got.open_depth));
                return;
            end
            want = expected_q.pop_front();
            if (got.balanced !== want.balanced || got.mismatch !== want.mismatch ||
                got.overflow !== want.overflow || got.open_depth !== want.open_depth)
                flag($sformatf({"result %0d: expected bal=%0b mis=%0b ovf=%0b depth=%0d, ",
                                "got bal=%0b mis=%0b ovf=%0b depth=%0d"},
                               results_seen, want.balanced, want.mismatch, want.overflow,
                               want.open_depth, got.balanced, got.mismatch, got.overflow,
                               got.open_depth));
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
                flag($sformatf("%0d results never arrived", expected_q.size()));
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for the bracket balance checker: clock, reset, drivers and checking
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;
    import bbc_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bbc_stream_if #(.payload_t(char_item_t))   chars_if ();
    bbc_stream_if #(.payload_t(result_item_t)) results_if ();

    bracket_balance_checker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    bracket_scoreboard sb = new();

    logic [7:0]  expr_q [$];
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;
    bit          sender_quiet = 1'b0;
    bit          sink_quiet   = 1'b0;
    bit          hold_off_req = 1'b0;

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Offer every character of expr_q in turn, last flag on the final one
    task automatic send_expr();
        int unsigned i;
        int unsigned gap;
        for (i = 0; i < expr_q.size(); i++) begin
            chars_if.valid <= 1'b1;
            chars_if.data  <= '{character: expr_q[i], last_char: (i == expr_q.size() - 1)};
            do
                @(posedge clk);
            while (!chars_if.ready);
            items_sent++;
            gap = sender_quiet ? 0 : pick_gap();
            if (gap > 0) begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        int unsigned i;
        expr_q.delete();
        for (i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
        send_expr();
    endtask

    // Hold the input idle until every outstanding verdict has been returned
    task automatic drain_results();
        chars_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic build_random_expr();
        bracket_kind_e open_kinds [$];
        bracket_kind_e k;
        logic [7:0]    c;
        int unsigned   len;
        int unsigned   roll;
        int unsigned   style;
        int unsigned   i;
        expr_q.delete();
        // style 0: pure noise; 1..2: broken; otherwise well formed
        style = $urandom_range(0, 9);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
        for (i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (style == 0)
                expr_q.push_back(8'($urandom_range(0, 255)));
            else if (roll < 35) begin
                k = bracket_kind_e'($urandom_range(0, 2));
                open_kinds.push_back(k);
                expr_q.push_back(opener_char(k));
            end
            else if (roll < 65 && open_kinds.size() != 0)
                expr_q.push_back(closer_char(open_kinds.pop_back()));
            else if (roll >= 92 && style <= 2)
                // stray closer of a random kind: may be the wrong kind, or one too many
                expr_q.push_back(closer_char(bracket_kind_e'($urandom_range(0, 2))));
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (opener_kind_of(c) != KIND_NONE || closer_kind_of(c) != KIND_NONE);
                expr_q.push_back(c);
            end
        end
        // close what is still open; broken ones may leave some brackets open
        while (open_kinds.size() != 0 && style != 0 &&
               !(style <= 2 && $urandom_range(0, 3) == 0))
            expr_q.push_back(closer_char(open_kinds.pop_back()));
    endtask

    initial
    begin : stimulus
        bracket_kind_e deep_kinds [$];
        bracket_kind_e k;
        int unsigned   i;
        int unsigned   n;
        int unsigned   random_start;
        chars_if.valid   = 1'b0;
        chars_if.data    = '0;
        results_if.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("()");
        send_text("[{}]");
        send_text("(]");
        send_text(")");
        send_text("x");
        send_text("((");
        send_text(")(");
        send_text("{)]");
        send_text("a(b)c");
        expr_q.delete();
        expr_q.push_back(8'h00);
        expr_q.push_back(8'hFF);
        expr_q.push_back(CH_OPEN_CURLY);
        send_expr();

        // full stack and one opener beyond it
        expr_q.delete();
        for (i = 0; i <= BRACKET_DEPTH; i++)
            expr_q.push_back(opener_char(bracket_kind_e'($urandom_range(0, 2))));
        send_expr();

        // fill to the brim and unwind completely
        expr_q.delete();
        for (i = 0; i < BRACKET_DEPTH; i++) begin
            k = bracket_kind_e'($urandom_range(0, 2));
            deep_kinds.push_back(k);
            expr_q.push_back(opener_char(k));
        end
        while (deep_kinds.size() != 0)
            expr_q.push_back(closer_char(deep_kinds.pop_back()));
        send_expr();

        random_start = items_sent;
        n = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (n == 20)
                hold_off_req = 1'b1;
            if (n == 60)
                drain_results();
            if (n >= 20 && n < 50)
                sender_quiet = 1'b1;
            else if ($urandom_range(0, 9) == 0)
                sender_quiet = !sender_quiet;
            if ($urandom_range(0, 9) == 0)
                sink_quiet = !sink_quiet;
            build_random_expr();
            send_expr();
            n++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        sb.check_drained();
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
                if (!sink_quiet)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (chars_if.valid && chars_if.ready)
                sb.note_char(chars_if.data);
            if (results_if.valid && results_if.ready)
                sb.check_result(results_if.data);
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
